>>> rtl/motion_point_sequencer_macros.svh
// assertion macros for the motion point sequencer
`ifndef MOTION_POINT_SEQUENCER_MACROS_SVH
`define MOTION_POINT_SEQUENCER_MACROS_SVH

`ifndef ASSERT_OFF
`define MPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define MPS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define MPS_ASSERT(lbl, prop, msg)
`define MPS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/mps_pkg.sv
package mps_pkg;

    localparam int MPS_MAX_MOTORS = 8;
    localparam int MPS_MAX_POINTS = 1024;

    localparam logic [3:0]  MPS_RST_MOTOR_COUNT = 4'd5;
    localparam logic [23:0] MPS_RST_REACH_SQ    = 24'd2500;
    localparam logic [23:0] MPS_RST_STILL_SQ    = 24'd900;
    localparam logic [23:0] MPS_RST_RESEND      = 24'd500000;
    localparam logic [23:0] MPS_RST_INTERP      = 24'd16000;

    localparam logic [2:0] CFG_MOTOR_COUNT = 3'd0;
    localparam logic [2:0] CFG_REACH_SQ    = 3'd1;
    localparam logic [2:0] CFG_STILL_SQ    = 3'd2;
    localparam logic [2:0] CFG_RESEND      = 3'd3;
    localparam logic [2:0] CFG_INTERP      = 3'd4;

    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_LOAD   = 2'd1;
    localparam logic [1:0] MODE_REPORT = 2'd2;
    localparam logic [1:0] MODE_START  = 2'd3;

    localparam logic [1:0] KIND_TARGET   = 2'd0;
    localparam logic [1:0] KIND_SYNC     = 2'd1;
    localparam logic [1:0] KIND_COMPLETE = 2'd2;

    typedef logic [23:0] t_thr;

    // squared distance below threshold; anything at or above 4096 squares past 24 bits
    function automatic logic sq_below(input logic signed [32:0] d, input t_thr thr);
        logic [32:0] mag;
        logic [23:0] sq;
        mag = d[32] ? 33'(-d) : 33'(d);
        sq  = 24'(mag[11:0]) * 24'(mag[11:0]);
        return (mag[32:12] == 21'd0) && (sq < thr);
    endfunction

endpackage

>>> rtl/motion_point_sequencer.sv
// motion point sequencer
// input channel (i_in_valid / o_in_ready) takes one command word at a time:
// tick, load point word, joint position report or start trace. the output
// channel (o_out_valid / i_out_ready) carries target commands, sync frames
// and the trace complete word; o_last marks the final word caused by a command.
// configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data).
// one command is handled at a time. load, start and idle ticks pass through
// S_EXEC only, a position report adds S_CHECK when a joint newly settles, and a
// tick on a sent point goes S_EXEC then S_MODE. a tick that sends a point
// produces one word per joint in use, each read from the point table through a
// registered read port and held until the receiver raises i_out_ready; an
// interpolated point adds a sync word, and trace complete is held the same way.
// the next command is taken once the last word of the current one is taken;
// while the receiver stalls the output word holds and o_in_ready stays low.
// synchronous reset (i_rst_n low) clears the point count, trace state,
// joint flags and positions and loads the default configuration; the point
// table is not cleared and needs no clearing pass.
module motion_point_sequencer
    import mps_pkg::*;
#(
    parameter int MAX_MOTORS = MPS_MAX_MOTORS,
    parameter int MAX_POINTS = MPS_MAX_POINTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [23:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_mode,
    input  logic [2:0]         i_motor_index,
    input  logic signed [31:0] i_value,
    input  logic               i_move_mode,
    input  logic               i_point_end,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_kind,
    output logic [2:0]         o_motor_index_res,
    output logic signed [31:0] o_target_position,
    output logic               o_move_mode_res,
    output logic               o_last
);

    `include "motion_point_sequencer_macros.svh"

    localparam int MIW = (MAX_MOTORS > 1) ? $clog2(MAX_MOTORS) : 1;
    localparam int MCW = $clog2(MAX_MOTORS + 1);
    localparam int PCW = $clog2(MAX_POINTS + 1);
    localparam int PAW = $clog2(MAX_POINTS);
    localparam int TAW = $clog2(MAX_POINTS * MAX_MOTORS);

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_MODE, S_RD, S_SEND, S_OUT, S_CHECK
    } t_state;

    t_state r_state;

    logic [3:0]  r_motor_count;
    t_thr        r_reach_thr, r_still_thr, r_resend, r_interp;

    logic [1:0]  r_mode;
    logic [2:0]  r_idx;
    logic [31:0] r_val;
    logic        r_mm_in, r_end;

    logic [PCW-1:0] r_pcount, r_trace;
    logic           r_sent;
    logic [23:0]    r_elapsed;
    logic [31:0]    r_pos [MAX_MOTORS];
    logic [31:0]    r_tgt [MAX_MOTORS];
    logic [MAX_MOTORS-1:0] r_reached, r_still, r_rep;
    logic           r_all_reached, r_all_still;
    logic [MIW-1:0] r_m;
    logic [TAW-1:0] r_base;
    logic           r_pmm;

    logic [1:0]  r_o_kind;
    logic [2:0]  r_o_idx;
    logic [31:0] r_o_tgt;
    logic        r_o_mm, r_o_last;

    logic [MCW-1:0] motors_n;
    logic           last_m, idx_ok, load_ok, tgt_we, mode_we;
    logic [MIW-1:0] ri;
    logic [TAW-1:0] tgt_waddr, tgt_raddr;
    logic [31:0]    tgt_rdata;
    logic [0:0]     mode_rdata;
    logic           rep_r, rep_s, reach_all, still_all;
    logic [23:0]    e_inc;

    always_comb begin
        if (r_motor_count == 4'd0) begin
            motors_n = MCW'(1);
        end else if (32'(r_motor_count) > 32'(MAX_MOTORS)) begin
            motors_n = MCW'(MAX_MOTORS);
        end else begin
            motors_n = MCW'(r_motor_count);
        end
    end

    assign last_m    = (MCW'(r_m) + MCW'(1)) == motors_n;
    assign idx_ok    = 32'(r_idx) < 32'(MAX_MOTORS);
    assign ri        = MIW'(r_idx);
    assign load_ok   = (r_trace == '0) && (r_pcount < PCW'(MAX_POINTS)) && idx_ok;
    assign tgt_we    = (r_state == S_EXEC) && (r_mode == MODE_LOAD) && load_ok;
    assign mode_we   = tgt_we && r_end;
    assign tgt_waddr = TAW'(TAW'(r_pcount) * TAW'(MAX_MOTORS) + TAW'(r_idx));
    assign tgt_raddr = r_base + TAW'(r_m);
    assign e_inc     = (r_elapsed != 24'hFFFFFF) ? r_elapsed + 24'd1 : r_elapsed;

    assign rep_r = sq_below({r_tgt[ri][31], r_tgt[ri]} - {r_val[31], r_val}, r_reach_thr);
    assign rep_s = sq_below({r_pos[ri][31], r_pos[ri]} - {r_val[31], r_val}, r_still_thr);

    always_comb begin
        reach_all = 1'b1;
        still_all = 1'b1;
        for (int m = 0; m < MAX_MOTORS; m++) begin
            if (MCW'(m) < motors_n) begin
                reach_all = reach_all & r_reached[m];
                still_all = still_all & r_still[m];
            end
        end
    end

    mps_ram #(.WIDTH(32), .DEPTH(MAX_POINTS * MAX_MOTORS)) u_tgt_ram (
        .i_clk   (i_clk),
        .i_we    (tgt_we),
        .i_waddr (tgt_waddr),
        .i_wdata (r_val),
        .i_raddr (tgt_raddr),
        .o_rdata (tgt_rdata)
    );

    mps_ram #(.WIDTH(1), .DEPTH(MAX_POINTS)) u_mode_ram (
        .i_clk   (i_clk),
        .i_we    (mode_we),
        .i_waddr (PAW'(r_pcount)),
        .i_wdata (r_mm_in),
        .i_raddr (PAW'(r_trace - PCW'(1))),
        .o_rdata (mode_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_motor_count <= MPS_RST_MOTOR_COUNT;
            r_reach_thr   <= MPS_RST_REACH_SQ;
            r_still_thr   <= MPS_RST_STILL_SQ;
            r_resend      <= MPS_RST_RESEND;
            r_interp      <= MPS_RST_INTERP;
            r_pcount      <= '0;
            r_trace       <= '0;
            r_sent        <= 1'b0;
            r_elapsed     <= '0;
            r_reached     <= '0;
            r_still       <= '0;
            r_rep         <= '0;
            r_all_reached <= 1'b0;
            r_all_still   <= 1'b0;
            r_m           <= '0;
            for (int m = 0; m < MAX_MOTORS; m++) begin
                r_pos[m] <= '0;
                r_tgt[m] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MOTOR_COUNT: r_motor_count <= i_cfg_data[3:0];
                    CFG_REACH_SQ:    r_reach_thr   <= i_cfg_data;
                    CFG_STILL_SQ:    r_still_thr   <= i_cfg_data;
                    CFG_RESEND:      r_resend      <= i_cfg_data;
                    CFG_INTERP:      r_interp      <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_mode  <= i_mode;
                        r_idx   <= i_motor_index;
                        r_val   <= i_value;
                        r_mm_in <= i_move_mode;
                        r_end   <= i_point_end;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                    case (r_mode)
                        MODE_TICK: begin
                            if (r_trace == '0) begin
                                r_state <= S_IDLE;
                            end else if (r_trace > r_pcount) begin
                                if (r_all_still && r_all_reached) begin
                                    r_o_kind  <= KIND_COMPLETE;
                                    r_o_idx   <= 3'd0;
                                    r_o_tgt   <= '0;
                                    r_o_mm    <= 1'b0;
                                    r_o_last  <= 1'b1;
                                    r_pcount  <= '0;
                                    r_trace   <= '0;
                                    r_sent    <= 1'b0;
                                    r_elapsed <= '0;
                                    r_state   <= S_OUT;
                                end
                            end else begin
                                r_base  <= TAW'(TAW'(r_trace - PCW'(1)) * TAW'(MAX_MOTORS));
                                r_m     <= '0;
                                r_state <= S_MODE;
                            end
                        end
                        MODE_LOAD: begin
                            if (load_ok && r_end) begin
                                r_pcount <= r_pcount + PCW'(1);
                            end
                        end
                        MODE_REPORT: begin
                            if (idx_ok) begin
                                r_pos[ri]     <= r_val;
                                r_reached[ri] <= rep_r;
                                r_still[ri]   <= rep_s;
                                if (rep_r && rep_s) begin
                                    if (!r_rep[ri]) begin
                                        r_rep[ri] <= 1'b1;
                                        r_state   <= S_CHECK;
                                    end
                                end else begin
                                    r_rep[ri] <= 1'b0;
                                end
                            end
                        end
                        default: begin
                            if (r_trace == '0 && r_pcount != '0) begin
                                r_trace   <= PCW'(1);
                                r_sent    <= 1'b0;
                                r_elapsed <= '0;
                            end
                        end
                    endcase
                end
                S_MODE: begin
                    r_pmm <= mode_rdata[0];
                    if (!r_sent) begin
                        r_sent        <= 1'b1;
                        r_elapsed     <= '0;
                        r_all_reached <= 1'b0;
                        r_all_still   <= 1'b0;
                        r_state       <= S_SEND;
                    end else begin
                        r_state <= S_IDLE;
                        if (mode_rdata[0]) begin
                            if (e_inc >= r_interp) begin
                                r_trace   <= r_trace + PCW'(1);
                                r_sent    <= 1'b0;
                                r_elapsed <= '0;
                            end else begin
                                r_elapsed <= e_inc;
                            end
                        end else if (!r_all_still) begin
                            r_elapsed <= '0;
                        end else if (r_all_reached) begin
                            r_trace   <= r_trace + PCW'(1);
                            r_sent    <= 1'b0;
                            r_elapsed <= '0;
                        end else if (e_inc > r_resend) begin
                            r_sent    <= 1'b0;
                            r_elapsed <= '0;
                        end else begin
                            r_elapsed <= e_inc;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_SEND;
                end
                S_SEND: begin
                    r_tgt[r_m]     <= tgt_rdata;
                    r_reached[r_m] <= 1'b0;
                    r_still[r_m]   <= 1'b0;
                    r_rep[r_m]     <= 1'b0;
                    r_o_kind       <= KIND_TARGET;
                    r_o_idx        <= 3'(r_m);
                    r_o_tgt        <= tgt_rdata;
                    r_o_mm         <= r_pmm;
                    r_o_last       <= last_m && !r_pmm;
                    r_state        <= S_OUT;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        if (r_o_last) begin
                            r_state <= S_IDLE;
                        end else if (!last_m) begin
                            r_m     <= r_m + MIW'(1);
                            r_state <= S_RD;
                        end else begin
                            // sync word after the last joint of an interpolated point
                            r_o_kind <= KIND_SYNC;
                            r_o_idx  <= 3'd0;
                            r_o_tgt  <= '0;
                            r_o_mm   <= 1'b1;
                            r_o_last <= 1'b1;
                        end
                    end
                end
                S_CHECK: begin
                    r_all_reached <= reach_all;
                    if (reach_all) begin
                        r_all_still <= still_all;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = (r_state == S_OUT);
    assign o_kind            = r_o_kind;
    assign o_motor_index_res = r_o_idx;
    assign o_target_position = r_o_tgt;
    assign o_move_mode_res   = r_o_mm;
    assign o_last            = r_o_last;

    `MPS_ASSERT(a_no_overlap, !(o_in_ready && o_out_valid), "input taken while a word is pending")
    `MPS_ASSERT(a_trace_range, ({1'b0, r_trace} <= {1'b0, r_pcount} + 1'b1), "trace index past table end")
    `MPS_ASSERT(a_count_range, (32'(r_pcount) <= 32'(MAX_POINTS)), "point count past table size")
    `MPS_ASSERT(a_last_ends, (o_out_valid && i_out_ready && o_last) |=> !o_out_valid, "word after last")
    `MPS_ASSERT(a_load_idle, tgt_we |-> (r_trace == '0), "table written while tracing")

endmodule

>>> rtl/mps_ram.sv
module mps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
